>>> src/sorps_pkg.sv
// ----------------------------------------------------------------------------
// SOR pressure sweep package
// Shared types, register codes, widths and fixed-point helpers.
// ----------------------------------------------------------------------------
package sorps_pkg;

  localparam int MAX_CELLS_X_DEFAULT = 64;
  localparam int MAX_CELLS_Y_DEFAULT = 64;

  localparam int IN_DATA_W  = 48;   // index_x, index_y, cell_value, padded
  localparam int IN_USER_W  = 2;    // op
  localparam int OUT_DATA_W = 128;  // read_value, residual_max, residual_sum_squares
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 4;

  // datapath widths: operand, product and signed working value
  localparam int OP_A_W = 35;
  localparam int OP_B_W = 32;
  localparam int PROD_W = OP_A_W + OP_B_W;
  localparam int VAL_W  = PROD_W - 16 + 2;
  localparam int RLO_W  = PROD_W + 1 - 32;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DX_SQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DY_SQ = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOR_GAIN  = 3'd5;

  localparam logic [6:0]  CELLS_X_RESET  = 7'd64;
  localparam logic [6:0]  CELLS_Y_RESET  = 7'd64;
  localparam logic [17:0] OMEGA_RESET    = 18'd111411;
  localparam logic [30:0] INV_DX_RESET   = 31'd268435456;
  localparam logic [30:0] INV_DY_RESET   = 31'd268435456;
  localparam logic [31:0] SOR_GAIN_RESET = 32'd445645;

  localparam logic [30:0] SAT31      = 31'h7FFF_FFFF;
  localparam logic [62:0] SAT63      = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] SQ_LIMIT   = 32'd3037000499;

  typedef enum logic [1:0] {
    OP_LOAD_P   = 2'd0,
    OP_LOAD_RHS = 2'd1,
    OP_SWEEP    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BND_RD,
    ST_BND_WR,
    ST_SOR_RD,
    ST_SOR_CALC,
    ST_RES_RD,
    ST_RES_CALC,
    ST_READ_WAIT
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [6:0]  index_x;
    logic [6:0]  index_y;
    logic [31:0] cell_value;
    logic        in_range;
  } item_t;

  typedef struct packed {
    logic [6:0]  cells_x;
    logic [6:0]  cells_y;
    logic [17:0] omega;
    logic [30:0] inv_dx_squared;
    logic [30:0] inv_dy_squared;
    logic [31:0] sor_gain;
  } cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] read_value;
    logic [30:0] residual_max;
    logic [62:0] residual_sum_squares;
  } result_t;

  function automatic logic [VAL_W-1:0] mag_of(input logic signed [VAL_W-1:0] v);
    return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
  endfunction

  // round(prod / 2^16), ties away from zero, sign applied afterwards
  function automatic logic signed [VAL_W-1:0] round_q16(input logic [PROD_W-1:0] prod,
                                                        input logic neg);
    logic [PROD_W:0]          s;
    logic signed [VAL_W-1:0]  m;
    s = {1'b0, prod} + (PROD_W+1)'(32768);
    m = $signed({1'b0, s[PROD_W:16]});
    return neg ? -m : m;
  endfunction

endpackage

>>> src/sorps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sorps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4356
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sorps_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO between the intake and the sweep engine.
// ----------------------------------------------------------------------------
module sorps_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sorps_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output sorps_pkg::item_t head,
  output logic           valid
);
  import sorps_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

>>> src/sorps_front.sv
// ----------------------------------------------------------------------------
// Command intake
// Unpack input beats, classify the op and range-check the cell index.
// ----------------------------------------------------------------------------
module sorps_front #(
  parameter int MAX_CELLS_X = sorps_pkg::MAX_CELLS_X_DEFAULT,
  parameter int MAX_CELLS_Y = sorps_pkg::MAX_CELLS_Y_DEFAULT
) (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sorps_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [sorps_pkg::IN_USER_W-1:0] s_tuser,
  input  logic                            q_full,
  output logic                            q_push,
  output sorps_pkg::item_t                q_item
);
  import sorps_pkg::*;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_item.op         = op_t'(s_tuser);
    q_item.index_x    = s_tdata[6:0];
    q_item.index_y    = s_tdata[13:7];
    q_item.cell_value = s_tdata[45:14];
    q_item.in_range   = (32'(s_tdata[6:0]) <= 32'(MAX_CELLS_X + 1)) &&
                        (32'(s_tdata[13:7]) <= 32'(MAX_CELLS_Y + 1));
  end

endmodule

>>> src/sorps_engine.sv
// ----------------------------------------------------------------------------
// Sweep engine
// Execute loads, reads and sweeps against the pressure and rhs memories.
// ----------------------------------------------------------------------------
module sorps_engine #(
  parameter int MAX_CELLS_X = sorps_pkg::MAX_CELLS_X_DEFAULT,
  parameter int MAX_CELLS_Y = sorps_pkg::MAX_CELLS_Y_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  sorps_pkg::cfg_t    cfg,
  input  logic               q_valid,
  input  sorps_pkg::item_t   q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sorps_pkg::result_t out_res
);
  import sorps_pkg::*;

  localparam int CXW   = $clog2(MAX_CELLS_X + 2);
  localparam int CYW   = $clog2(MAX_CELLS_Y + 2);
  localparam int DEPTH = (MAX_CELLS_X + 2) * (MAX_CELLS_Y + 2);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ROWS_A = AW'(MAX_CELLS_Y + 2);
  localparam logic [3:0] SOR_LAST = 4'd9;
  localparam logic [3:0] RES_LAST = 4'd7;
  localparam logic [2:0] RD_LAST  = 3'd5;

  function automatic logic [AW-1:0] cell_addr(input logic [CXW-1:0] x,
                                              input logic [CYW-1:0] y);
    return AW'(x) * ROWS_A + AW'(y);
  endfunction

  state_t state, state_next;

  logic [2:0]      cnt;
  logic [3:0]      step;
  logic [CXW-1:0]  i;
  logic [CYW-1:0]  j;
  logic [CXW-1:0]  nx;
  logic [CYW-1:0]  ny;
  logic            col_phase;
  logic            half;
  logic            rd_in_range;

  logic signed [31:0] tap_p, tap_e, tap_w, tap_n, tap_s, tap_r;
  logic signed [VAL_W-1:0] lx, ly, t1, bval, t2, rx, ry, rres;
  logic [RLO_W-1:0]  rlo;
  logic [OP_A_W-1:0] op_a;
  logic [OP_B_W-1:0] op_b;
  logic [PROD_W-1:0] prod;
  logic neg_x, neg_y, neg_p, neg_b, sq_sat;
  logic [30:0] running_max;
  logic [62:0] running_sum;

  // memory ports
  logic          p_we, r_we;
  logic [AW-1:0] p_waddr, p_raddr, r_waddr, r_raddr;
  logic [31:0]   p_wdata, p_rdata, r_wdata, r_rdata;

  // datapath combinational values
  logic signed [VAL_W-1:0] sum_x, sum_y, v_new, b_next;
  logic [VAL_W-1:0]        mag_x, mag_y, mag_p, mag_b, mag_r;
  logic [31:0]             v_sat;
  logic [PROD_W:0]         lo_round;
  logic [VAL_W-2:0]        t2_mag;
  logic [30:0]             m_clip;
  logic [63:0]             sq;
  logic [64:0]             sum_wide;
  logic [AW-1:0]           src_addr, dst_addr, item_addr, center_addr;

  sorps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pressure (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  sorps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_rhs (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // clamp cell counts into 1..max
  always_comb begin
    if (cfg.cells_x == '0) begin
      nx = CXW'(1);
    end else if (32'(cfg.cells_x) > 32'(MAX_CELLS_X)) begin
      nx = CXW'(MAX_CELLS_X);
    end else begin
      nx = CXW'(cfg.cells_x);
    end
    if (cfg.cells_y == '0) begin
      ny = CYW'(1);
    end else if (32'(cfg.cells_y) > 32'(MAX_CELLS_Y)) begin
      ny = CYW'(MAX_CELLS_Y);
    end else begin
      ny = CYW'(cfg.cells_y);
    end
  end

  // ghost copy: rows first, then columns
  always_comb begin
    if (!col_phase) begin
      src_addr = half ? cell_addr(i, ny) : cell_addr(i, CYW'(1));
      dst_addr = half ? cell_addr(i, ny + CYW'(1)) : cell_addr(i, '0);
    end else begin
      src_addr = half ? cell_addr(nx, j) : cell_addr(CXW'(1), j);
      dst_addr = half ? cell_addr(nx + CXW'(1), j) : cell_addr('0, j);
    end
  end

  assign item_addr   = cell_addr(CXW'(q_item.index_x), CYW'(q_item.index_y));
  assign center_addr = cell_addr(i, j);

  always_comb begin
    sum_x = VAL_W'(tap_e) + VAL_W'(tap_w);
    sum_y = VAL_W'(tap_n) + VAL_W'(tap_s);
    if (state == ST_RES_CALC) begin
      sum_x = sum_x - (VAL_W'(tap_p) <<< 1);
      sum_y = sum_y - (VAL_W'(tap_p) <<< 1);
    end
    mag_x    = mag_of(sum_x);
    mag_y    = mag_of(sum_y);
    mag_p    = mag_of(VAL_W'(tap_p));
    mag_b    = mag_of(bval);
    mag_r    = mag_of(rres);
    b_next   = lx + ly - VAL_W'(tap_r);
    lo_round = {1'b0, prod} + (PROD_W+1)'(64'h8000_0000);
    t2_mag   = prod[VAL_W-2:0] + (VAL_W-1)'(rlo);
    v_new    = VAL_W'(tap_p) - t1 + t2;
    if (!v_new[VAL_W-1] && |v_new[VAL_W-2:31]) begin
      v_sat = 32'h7FFF_FFFF;
    end else if (v_new[VAL_W-1] && !(&v_new[VAL_W-2:31])) begin
      v_sat = 32'h8000_0000;
    end else begin
      v_sat = v_new[31:0];
    end
    m_clip   = (|mag_r[VAL_W-1:31]) ? SAT31 : mag_r[30:0];
    sq       = sq_sat ? {1'b0, SAT63} : prod[63:0];
    sum_wide = {2'b00, running_sum} + {1'b0, sq};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    p_we       = 1'b0;
    p_waddr    = item_addr;
    p_wdata    = q_item.cell_value;
    p_raddr    = item_addr;
    r_we       = 1'b0;
    r_waddr    = item_addr;
    r_wdata    = q_item.cell_value;
    r_raddr    = center_addr;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && (q_item.op == OP_LOAD_P || q_item.op == OP_LOAD_RHS || !out_valid)) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_LOAD_P:   p_we = q_item.in_range;
            OP_LOAD_RHS: r_we = q_item.in_range;
            OP_SWEEP:    state_next = ST_BND_RD;
            OP_READ:     state_next = ST_READ_WAIT;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ_WAIT: state_next = ST_IDLE;
      ST_BND_RD: begin
        p_raddr    = src_addr;
        state_next = ST_BND_WR;
      end
      ST_BND_WR: begin
        p_we    = 1'b1;
        p_waddr = dst_addr;
        p_wdata = p_rdata;
        if (col_phase && half && j == ny + CYW'(1)) begin
          state_next = ST_SOR_RD;
        end else begin
          state_next = ST_BND_RD;
        end
      end
      ST_SOR_RD, ST_RES_RD: begin
        unique case (cnt)
          3'd0:    p_raddr = center_addr;
          3'd1:    p_raddr = cell_addr(i + CXW'(1), j);
          3'd2:    p_raddr = cell_addr(i - CXW'(1), j);
          3'd3:    p_raddr = cell_addr(i, j + CYW'(1));
          3'd4:    p_raddr = cell_addr(i, j - CYW'(1));
          default: p_raddr = center_addr;
        endcase
        if (cnt == RD_LAST) begin
          state_next = (state == ST_SOR_RD) ? ST_SOR_CALC : ST_RES_CALC;
        end
      end
      ST_SOR_CALC: begin
        if (step == SOR_LAST) begin
          p_we    = 1'b1;
          p_waddr = center_addr;
          p_wdata = v_sat;
          state_next = (i == nx && j == ny) ? ST_RES_RD : ST_SOR_RD;
        end
      end
      ST_RES_CALC: begin
        if (step == RES_LAST) begin
          state_next = (i == nx && j == ny) ? ST_IDLE : ST_RES_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      cnt         <= '0;
      step        <= '0;
      i           <= '0;
      j           <= '0;
      col_phase   <= 1'b0;
      half        <= 1'b0;
      running_max <= '0;
      running_sum <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            rd_in_range <= q_item.in_range;
            i           <= '0;
            j           <= '0;
            col_phase   <= 1'b0;
            half        <= 1'b0;
            cnt         <= '0;
            running_max <= '0;
            running_sum <= '0;
          end
        end
        ST_READ_WAIT: begin
          out_valid                    <= 1'b1;
          out_res.result_kind          <= 1'b0;
          out_res.read_value           <= rd_in_range ? p_rdata : '0;
          out_res.residual_max         <= '0;
          out_res.residual_sum_squares <= '0;
        end
        ST_BND_WR: begin
          half <= !half;
          if (half) begin
            if (!col_phase) begin
              if (i == nx + CXW'(1)) begin
                col_phase <= 1'b1;
                j         <= '0;
              end else begin
                i <= i + CXW'(1);
              end
            end else if (j == ny + CYW'(1)) begin
              i   <= CXW'(1);
              j   <= CYW'(1);
              cnt <= '0;
            end else begin
              j <= j + CYW'(1);
            end
          end
        end
        ST_SOR_RD, ST_RES_RD: begin
          case (cnt)
            3'd1: begin
              tap_p <= p_rdata;
              tap_r <= r_rdata;
            end
            3'd2:    tap_e <= p_rdata;
            3'd3:    tap_w <= p_rdata;
            3'd4:    tap_n <= p_rdata;
            3'd5:    tap_s <= p_rdata;
            default: tap_s <= tap_s;
          endcase
          if (cnt == RD_LAST) begin
            cnt  <= '0;
            step <= '0;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_SOR_CALC: begin
          step <= step + 4'd1;
          case (step)
            4'd0: begin
              op_a  <= OP_A_W'(mag_x);
              op_b  <= {1'b0, cfg.inv_dx_squared};
              neg_x <= sum_x[VAL_W-1];
            end
            4'd1: begin
              op_a  <= OP_A_W'(mag_y);
              op_b  <= {1'b0, cfg.inv_dy_squared};
              neg_y <= sum_y[VAL_W-1];
            end
            4'd2: begin
              lx    <= round_q16(prod, neg_x);
              op_a  <= OP_A_W'(mag_p);
              op_b  <= OP_B_W'(cfg.omega);
              neg_p <= tap_p[31];
            end
            4'd3: ly <= round_q16(prod, neg_y);
            4'd4: begin
              t1   <= round_q16(prod, neg_p);
              bval <= b_next;
            end
            4'd5: begin
              op_a  <= OP_A_W'(mag_b[31:0]);
              op_b  <= cfg.sor_gain;
              neg_b <= bval[VAL_W-1];
            end
            4'd6: op_a <= OP_A_W'(mag_b[VAL_W-1:32]);
            4'd7: rlo <= lo_round[PROD_W:32];
            4'd8: t2 <= neg_b ? -$signed({1'b0, t2_mag}) : $signed({1'b0, t2_mag});
            default: begin
              step <= '0;
              if (j == ny) begin
                j <= CYW'(1);
                i <= (i == nx) ? CXW'(1) : i + CXW'(1);
              end else begin
                j <= j + CYW'(1);
              end
            end
          endcase
        end
        ST_RES_CALC: begin
          step <= step + 4'd1;
          case (step)
            4'd0: begin
              op_a  <= OP_A_W'(mag_x);
              op_b  <= {1'b0, cfg.inv_dx_squared};
              neg_x <= sum_x[VAL_W-1];
            end
            4'd1: begin
              op_a  <= OP_A_W'(mag_y);
              op_b  <= {1'b0, cfg.inv_dy_squared};
              neg_y <= sum_y[VAL_W-1];
            end
            4'd2: rx <= round_q16(prod, neg_x);
            4'd3: ry <= round_q16(prod, neg_y);
            4'd4: rres <= rx + ry - VAL_W'(tap_r);
            4'd5: begin
              op_a   <= OP_A_W'(mag_r);
              op_b   <= mag_r[31:0];
              sq_sat <= mag_r > VAL_W'(SQ_LIMIT);
              if (m_clip > running_max) begin
                running_max <= m_clip;
              end
            end
            4'd6: sq_sat <= sq_sat;
            default: begin
              step <= '0;
              running_sum <= (sum_wide > 65'(SAT63)) ? SAT63 : sum_wide[62:0];
              if (j == ny) begin
                j <= CYW'(1);
                i <= i + CXW'(1);
              end else begin
                j <= j + CYW'(1);
              end
              if (i == nx && j == ny) begin
                out_valid                    <= 1'b1;
                out_res.result_kind          <= 1'b1;
                out_res.read_value           <= '0;
                out_res.residual_max         <= (m_clip > running_max) ? m_clip : running_max;
                out_res.residual_sum_squares <= (sum_wide > 65'(SAT63)) ? SAT63
                                                                        : sum_wide[62:0];
              end
            end
          endcase
        end
        default: cnt <= cnt;
      endcase
    end
  end

  // A result-producing command must never be taken while a result is pending.
  assert property (@(posedge clk) disable iff (rst)
    q_pop && (q_item.op == OP_SWEEP || q_item.op == OP_READ) |-> !out_valid)
    else $error("result command popped with output occupied");

  // Stencil fetch and residual pass must leave the pressure grid untouched.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SOR_RD || state == ST_RES_RD || state == ST_RES_CALC) |-> !p_we)
    else $error("pressure write during read-only phase");

  // Relaxation works on interior cells only.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SOR_CALC |-> (i != '0 && i <= nx && j != '0 && j <= ny))
    else $error("relaxation outside interior");

endmodule

>>> src/sor_pressure_poisson_sweep.sv
// ----------------------------------------------------------------------------
// SOR pressure Poisson sweep
// Five-point SOR Gauss-Seidel engine with residual norms, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive as beats on the s_ group; s_tuser carries the op (load
//   pressure, load rhs, sweep, read pressure). Loads give no result; a read
//   and a sweep each give one beat on the m_ group, m_tuser marking which.
//   Registers are written through the cfg_ channel while the block is idle.
//   the user is bound to this, as the block itself does not enforce it.
// Sequence:
//   A load writes its memory as the engine takes it; a read waits on the
//   registered pressure read data. A sweep first copies the ghost cells (one
//   read and one write of the pressure memory per copy), then relaxes every
//   interior cell, then takes the residual over every interior cell, each
//   cell using five pressure reads and the one shared multiplier.
// Reset:
//   Clears control state, the queue and the norm accumulators and restores
//   register defaults. Grid memories are not cleared; read cells only after
//   writing them.
// Stalls:
//   A four-entry queue keeps taking commands while the engine works or a
//   result waits on m_tready; when the result is held, loads still run but a
//   read or sweep waits in the queue.
// ----------------------------------------------------------------------------
module sor_pressure_poisson_sweep #(
  parameter int MAX_CELLS_X = sorps_pkg::MAX_CELLS_X_DEFAULT,
  parameter int MAX_CELLS_Y = sorps_pkg::MAX_CELLS_Y_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sorps_pkg::IN_DATA_W-1:0]  s_tdata,   // index_x, index_y, cell_value
  input  logic [sorps_pkg::IN_USER_W-1:0]  s_tuser,   // op
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sorps_pkg::OUT_DATA_W-1:0] m_tdata,   // read_value, residual_max,
                                                      // residual_sum_squares
  output logic                             m_tuser,   // result_kind
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sorps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sorps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sorps_pkg::*;

  cfg_t    cfg;
  item_t   push_item, head;
  logic    q_push, q_full, q_pop, q_valid;
  result_t res;

  // Registers accept a beat every cycle; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cells_x        <= CELLS_X_RESET;
      cfg.cells_y        <= CELLS_Y_RESET;
      cfg.omega          <= OMEGA_RESET;
      cfg.inv_dx_squared <= INV_DX_RESET;
      cfg.inv_dy_squared <= INV_DY_RESET;
      cfg.sor_gain       <= SOR_GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CELLS_X:   cfg.cells_x        <= cfg_data[6:0];
        REG_CELLS_Y:   cfg.cells_y        <= cfg_data[6:0];
        REG_OMEGA:     cfg.omega          <= cfg_data[17:0];
        REG_INV_DX_SQ: cfg.inv_dx_squared <= cfg_data[30:0];
        REG_INV_DY_SQ: cfg.inv_dy_squared <= cfg_data[30:0];
        REG_SOR_GAIN:  cfg.sor_gain       <= cfg_data;
        default:       cfg.sor_gain       <= cfg.sor_gain;
      endcase
    end
  end

  // Front: unpack and classify each command beat.
  sorps_front #(.MAX_CELLS_X(MAX_CELLS_X), .MAX_CELLS_Y(MAX_CELLS_Y)) u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_full(q_full), .q_push(q_push), .q_item(push_item)
  );

  // Queue: decouple intake from the engine.
  sorps_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(push_item), .full(q_full),
    .pop(q_pop), .head(head), .valid(q_valid)
  );

  // Back: memories, sweep sequencer and result register.
  sorps_engine #(.MAX_CELLS_X(MAX_CELLS_X), .MAX_CELLS_Y(MAX_CELLS_Y)) u_engine (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_item(head), .q_pop(q_pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tuser = res.result_kind;
  assign m_tdata = {2'b00, res.residual_sum_squares, res.residual_max, res.read_value};

endmodule
